// File: rtl/ptc_pkg.sv
// Shared types, constants and helpers for the pressure/temperature compensation core.
// Used by every module under rtl/.
package ptc_pkg;

  // Output clamp limits
  localparam int TEMP_MIN_CENTI  = -4000;
  localparam int TEMP_MAX_CENTI  = 8500;
  localparam int PRESS_MIN_CENTI = 3000000;
  localparam int PRESS_MAX_CENTI = 11000000;

  // Datapath constants
  localparam int TFINE_OFFSET = 128000;
  localparam logic signed [63:0] PRESS_OFFSET = 64'sd140737488355328;
  localparam logic [20:0] RAW_FULL_SCALE = 21'd1048576;
  localparam logic [11:0] PRESS_SCALE = 12'd3125;
  localparam logic [6:0] CENTI_SCALE = 7'd100;

  // Divider: quotient bits resolved per pipeline stage
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = 64 / DIV_BITS;

  // Configuration register indexes
  localparam logic [1:0] REG_TEMP_CALIB  = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
  localparam logic [1:0] REG_PRESS_MID   = 2'd2;
  localparam logic [1:0] REG_PRESS_LAST  = 2'd3;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } calib_t;

  typedef struct packed {
    logic               divisor_zero;
    logic [23:0]        pressure_centi_pa;
    logic signed [14:0] temperature_centi;
  } result_t;

  // Signed divide by 2**k, truncating toward zero
  function automatic logic signed [63:0] div_pow2(input logic signed [63:0] x,
                                                  input int unsigned k);
    logic [63:0] bias;
    bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
    return (x + $signed(bias)) >>> k;
  endfunction

endpackage

// File: rtl/ptc_temp.sv
// Temperature compensation pipeline: six stages from raw reading to t_fine and 0.01 degC.
// Depends on ptc_pkg.
module ptc_temp (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [19:0]        raw_t,
  input  logic [19:0]        raw_p,
  input  ptc_pkg::calib_t    calib,
  output logic               out_valid,
  output logic signed [14:0] temp_centi,
  output logic signed [24:0] t_fine,
  output logic [19:0]        raw_p_out
);
  import ptc_pkg::*;

  logic [5:0] vld;

  logic signed [18:0] s1_x1;
  logic signed [17:0] s1_d;
  logic [19:0]        s1_rp;
  logic signed [34:0] s2_m1;
  logic [31:0]        s2_dd;
  logic [19:0]        s2_rp;
  logic signed [23:0] s3_v1;
  logic [19:0]        s3_dds;
  logic [19:0]        s3_rp;
  logic signed [23:0] s4_v1;
  logic signed [36:0] s4_m2;
  logic [19:0]        s4_rp;
  logic signed [24:0] s5_tf;
  logic [19:0]        s5_rp;

  logic signed [18:0] x1_next;
  logic signed [17:0] d_next;
  logic signed [35:0] dd_full;
  logic signed [63:0] v1_w;
  logic signed [63:0] v2_w;
  logic signed [24:0] tf_next;
  logic signed [63:0] tv;
  logic signed [14:0] temp_next;

  always_comb begin
    x1_next = $signed({2'b00, raw_t[19:3]}) - $signed({2'b00, calib.t1, 1'b0});
    d_next  = $signed({2'b00, raw_t[19:4]}) - $signed({2'b00, calib.t1});
    dd_full = s1_d * s1_d;
    v1_w    = div_pow2(64'(s2_m1), 11);
    v2_w    = div_pow2(64'(s4_m2), 14);
    tf_next = 25'(s4_v1) + $signed(v2_w[24:0]);
    tv      = div_pow2(64'(s5_tf) * 64'sd5 + 64'sd128, 8);
    if (tv < 64'(TEMP_MIN_CENTI)) begin
      temp_next = 15'(TEMP_MIN_CENTI);
    end else if (tv > 64'(TEMP_MAX_CENTI)) begin
      temp_next = 15'(TEMP_MAX_CENTI);
    end else begin
      temp_next = tv[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x1      <= x1_next;
      s1_d       <= d_next;
      s1_rp      <= raw_p;
      s2_m1      <= s1_x1 * $signed(calib.t2);
      s2_dd      <= dd_full[31:0];
      s2_rp      <= s1_rp;
      s3_v1      <= v1_w[23:0];
      s3_dds     <= s2_dd[31:12];
      s3_rp      <= s2_rp;
      s4_v1      <= s3_v1;
      s4_m2      <= $signed({1'b0, s3_dds}) * $signed(calib.t3);
      s4_rp      <= s3_rp;
      s5_tf      <= tf_next;
      s5_rp      <= s4_rp;
      temp_centi <= temp_next;
      t_fine     <= s5_tf;
      raw_p_out  <= s5_rp;
    end
  end

  assign out_valid = vld[5];

endmodule

// File: rtl/ptc_press_pre.sv
// Pressure front end: builds dividend and divisor from t_fine, raw pressure and p1..p6.
// Nine stages; depends on ptc_pkg.
module ptc_press_pre (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [24:0] t_fine,
  input  logic [19:0]        raw_p,
  input  logic signed [14:0] temp_in,
  input  ptc_pkg::calib_t    calib,
  output logic               out_valid,
  output logic signed [63:0] num,
  output logic signed [31:0] den,
  output logic               zero,
  output logic signed [14:0] temp_out
);
  import ptc_pkg::*;

  logic [8:0] vld;
  logic signed [14:0] tmp [8];
  logic [19:0] rp [5];

  logic signed [25:0] p1_a;
  logic [51:0]        p2_aa;
  logic signed [41:0] p2_ap5;
  logic signed [41:0] p2_ap2;
  logic signed [48:0] p3_m6l;
  logic signed [36:0] p3_m6h;
  logic signed [48:0] p3_m3l;
  logic signed [36:0] p3_m3h;
  logic signed [63:0] p3_ap5s;
  logic signed [63:0] p3_ap2s;
  logic signed [63:0] p4_b0;
  logic signed [63:0] p4_c0;
  logic signed [63:0] p4_ap5s;
  logic signed [63:0] p4_ap2s;
  logic signed [63:0] p5_b;
  logic signed [63:0] p5_c;
  logic [63:0]        p6_e;
  logic [63:0]        p6_n1;
  logic [47:0]        p7_el;
  logic [47:0]        p7_eh;
  logic [43:0]        p7_nl;
  logic [43:0]        p7_nh;
  logic signed [63:0] p8_f;
  logic signed [63:0] p8_n;

  logic signed [51:0] aa_full;
  logic [20:0]        n0;
  logic signed [63:0] den_w;

  always_comb begin
    aa_full = p1_a * p1_a;
    n0      = RAW_FULL_SCALE - {1'b0, rp[4]};
    den_w   = div_pow2(p8_f, 33);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tmp[0] <= temp_in;
      for (int i = 1; i < 8; i++) begin
        tmp[i] <= tmp[i-1];
      end
      rp[0] <= raw_p;
      for (int i = 1; i < 5; i++) begin
        rp[i] <= rp[i-1];
      end
      // t_fine offset
      p1_a    <= 26'(t_fine) - 26'(TFINE_OFFSET);
      p2_aa   <= aa_full;
      p2_ap5  <= p1_a * $signed(calib.p5);
      p2_ap2  <= p1_a * $signed(calib.p2);
      // split the 52-bit square into 32-bit and 20-bit halves
      p3_m6l  <= $signed({1'b0, p2_aa[31:0]}) * $signed(calib.p6);
      p3_m6h  <= $signed({1'b0, p2_aa[51:32]}) * $signed(calib.p6);
      p3_m3l  <= $signed({1'b0, p2_aa[31:0]}) * $signed(calib.p3);
      p3_m3h  <= $signed({1'b0, p2_aa[51:32]}) * $signed(calib.p3);
      p3_ap5s <= 64'(p2_ap5) <<< 17;
      p3_ap2s <= 64'(p2_ap2) <<< 12;
      p4_b0   <= 64'(p3_m6l) + (64'(p3_m6h) <<< 32);
      p4_c0   <= 64'(p3_m3l) + (64'(p3_m3h) <<< 32);
      p4_ap5s <= p3_ap5s;
      p4_ap2s <= p3_ap2s;
      p5_b    <= p4_b0 + p4_ap5s + (64'($signed(calib.p4)) <<< 35);
      p5_c    <= div_pow2(p4_c0, 8) + p4_ap2s;
      p6_e    <= p5_c + PRESS_OFFSET;
      p6_n1   <= ({43'd0, n0} << 31) - p5_b;
      p7_el   <= p6_e[31:0] * calib.p1;
      p7_eh   <= p6_e[63:32] * calib.p1;
      p7_nl   <= p6_n1[31:0] * PRESS_SCALE;
      p7_nh   <= p6_n1[63:32] * PRESS_SCALE;
      p8_f    <= $signed({16'd0, p7_el} + {p7_eh[31:0], 32'd0});
      p8_n    <= $signed({20'd0, p7_nl} + {p7_nh[31:0], 32'd0});
      num      <= p8_n;
      den      <= den_w[31:0];
      zero     <= (den_w == 64'sd0);
      temp_out <= tmp[7];
    end
  end

  assign out_valid = vld[8];

endmodule

// File: rtl/ptc_div.sv
// Pipelined signed 64 / 32 divider, DIV_BITS quotient bits per stage, truncating.
// Carries temperature and zero flag alongside; depends on ptc_pkg.
module ptc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  input  logic               zero_in,
  input  logic signed [14:0] temp_in,
  output logic               out_valid,
  output logic signed [63:0] quot,
  output logic               zero_out,
  output logic signed [14:0] temp_out
);
  import ptc_pkg::*;

  // One valid bit for the magnitude stage, one per quotient stage, one for the sign stage
  logic [DIV_STAGES+1:0] vld;
  logic [31:0]        rem_s  [DIV_STAGES+1];
  logic [63:0]        wrk_s  [DIV_STAGES+1];
  logic [31:0]        dm_s   [DIV_STAGES+1];
  logic               neg_s  [DIV_STAGES+1];
  logic               zero_s [DIV_STAGES+1];
  logic signed [14:0] temp_s [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STAGES:0], in_valid};
    end
  end

  // Magnitudes and quotient sign
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= '0;
      wrk_s[0]  <= num[63] ? 64'(-num) : 64'(num);
      dm_s[0]   <= den[31] ? 32'(-den) : 32'(den);
      neg_s[0]  <= num[63] ^ den[31];
      zero_s[0] <= zero_in;
      temp_s[0] <= temp_in;
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [32:0] r_next;
    logic [63:0] w_next;

    always_comb begin
      r_next = {1'b0, rem_s[g]};
      w_next = wrk_s[g];
      for (int i = 0; i < DIV_BITS; i++) begin
        r_next = {r_next[31:0], w_next[63]};
        w_next = {w_next[62:0], 1'b0};
        if (r_next >= {1'b0, dm_s[g]}) begin
          r_next    = r_next - {1'b0, dm_s[g]};
          w_next[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1]  <= r_next[31:0];
        wrk_s[g+1]  <= w_next;
        dm_s[g+1]   <= dm_s[g];
        neg_s[g+1]  <= neg_s[g];
        zero_s[g+1] <= zero_s[g];
        temp_s[g+1] <= temp_s[g];
      end
    end
  end

  // Apply sign; the most negative dividend over -1 wraps back to itself
  always_ff @(posedge clk) begin
    if (en) begin
      quot     <= neg_s[DIV_STAGES] ? $signed(-wrk_s[DIV_STAGES])
                                    : $signed(wrk_s[DIV_STAGES]);
      zero_out <= zero_s[DIV_STAGES];
      temp_out <= temp_s[DIV_STAGES];
    end
  end

  assign out_valid = vld[DIV_STAGES+1];

endmodule

// File: rtl/ptc_press_post.sv
// Pressure back end: p7..p9 correction, final scale and clamp, thirteen stages.
// Depends on ptc_pkg.
module ptc_press_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [63:0] p_in,
  input  logic               zero_in,
  input  logic signed [14:0] temp_in,
  input  ptc_pkg::calib_t    calib,
  output logic               out_valid,
  output ptc_pkg::result_t   result
);
  import ptc_pkg::*;

  logic [12:0] vld;
  logic signed [14:0] tmp [12];
  logic               zr  [12];
  logic signed [63:0] pp  [6];
  logic signed [63:0] bb  [4];

  logic signed [63:0] q1_q;
  logic signed [48:0] q1_m8l;
  logic signed [47:0] q1_m8h;
  logic [63:0]        q2_sqll;
  logic [31:0]        q2_sqlh;
  logic signed [63:0] q2_b8;
  logic [63:0]        q3_sq;
  logic signed [48:0] q4_s9l;
  logic signed [47:0] q4_s9h;
  logic signed [63:0] q5_s9;
  logic signed [63:0] q6_a;
  logic signed [63:0] q7_r;
  logic signed [63:0] q8_t;
  logic signed [63:0] q9_u;
  logic [38:0]        q10_ul;
  logic [38:0]        q10_uh;
  logic signed [63:0] q11_v;
  logic signed [63:0] q12_pr;

  logic [63:0] sqlh_full;
  logic [23:0] press_next;

  always_comb begin
    sqlh_full = q1_q[31:0] * q1_q[63:32];
    if (q12_pr < 64'(PRESS_MIN_CENTI)) begin
      press_next = 24'(PRESS_MIN_CENTI);
    end else if (q12_pr > 64'(PRESS_MAX_CENTI)) begin
      press_next = 24'(PRESS_MAX_CENTI);
    end else begin
      press_next = q12_pr[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[11:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tmp[0] <= temp_in;
      zr[0]  <= zero_in;
      for (int i = 1; i < 12; i++) begin
        tmp[i] <= tmp[i-1];
        zr[i]  <= zr[i-1];
      end
      pp[0] <= p_in;
      for (int i = 1; i < 6; i++) begin
        pp[i] <= pp[i-1];
      end
      q1_q    <= div_pow2(p_in, 13);
      q1_m8l  <= $signed({1'b0, p_in[31:0]}) * $signed(calib.p8);
      q1_m8h  <= $signed(p_in[63:32]) * $signed(calib.p8);
      // low 64 bits of q*q from 32-bit halves
      q2_sqll <= q1_q[31:0] * q1_q[31:0];
      q2_sqlh <= sqlh_full[31:0];
      q2_b8   <= 64'(q1_m8l) + (64'(q1_m8h) <<< 32);
      q3_sq   <= q2_sqll + {q2_sqlh[30:0], 33'd0};
      bb[0]   <= div_pow2(q2_b8, 19);
      bb[1]   <= bb[0];
      bb[2]   <= bb[1];
      bb[3]   <= bb[2];
      q4_s9l  <= $signed({1'b0, q3_sq[31:0]}) * $signed(calib.p9);
      q4_s9h  <= $signed(q3_sq[63:32]) * $signed(calib.p9);
      q5_s9   <= 64'(q4_s9l) + (64'(q4_s9h) <<< 32);
      q6_a    <= div_pow2(q5_s9, 25);
      q7_r    <= pp[5] + q6_a + bb[3];
      q8_t    <= div_pow2(q7_r, 8) + (64'($signed(calib.p7)) <<< 4);
      q9_u    <= div_pow2(q8_t, 1);
      q10_ul  <= q9_u[31:0] * CENTI_SCALE;
      q10_uh  <= q9_u[63:32] * CENTI_SCALE;
      q11_v   <= $signed({25'd0, q10_ul} + {q10_uh[31:0], 32'd0});
      q12_pr  <= div_pow2(q11_v, 7);
      result.temperature_centi <= tmp[11];
      result.divisor_zero      <= zr[11];
      result.pressure_centi_pa <= zr[11] ? 24'd0 : press_next;
    end
  end

  assign out_valid = vld[12];

endmodule

// File: rtl/ptc_skid.sv
// Output register with one skid word; its ready is registered and stalls the pipeline.
// Depends on ptc_pkg.
module ptc_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ptc_pkg::result_t in_data,
  output logic             in_ready,
  output logic             out_valid,
  output ptc_pkg::result_t out_data,
  input  logic             out_ready
);
  import ptc_pkg::*;

  logic    sk_valid;
  result_t sk_data;

  assign in_ready = !sk_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (!sk_valid) begin
      if (!out_valid || out_ready) begin
        out_valid <= in_valid;
      end else if (in_valid) begin
        sk_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b1;
      sk_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_valid) begin
      if (!out_valid || out_ready) begin
        out_data <= in_data;
      end else begin
        sk_data <= in_data;
      end
    end else if (out_ready) begin
      out_data <= sk_data;
    end
  end

endmodule

// File: rtl/pressure_temperature_compensation_core.sv
// Pressure/temperature compensation core: temperature, t_fine and pressure per sample pair.
// Throughput: one word per cycle while the output skid word is empty.
// The 64/32 quotient is resolved two bits per stage in a 34-stage divider, which sets depth.
// rst (synchronous, active high) clears all valid bits, the output skid and calibration.
// Calibration may be rewritten only while the pipeline is empty.
// Depends on ptc_pkg, ptc_temp, ptc_press_pre, ptc_div, ptc_press_post, ptc_skid.
module pressure_temperature_compensation_core (
  input  logic        clk,
  input  logic        rst,
  // input word
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [19:0] raw_temperature, [39:20] raw_pressure
  // result word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [14:0] temperature_centi, [38:15] pressure_centi_pa, [39] 0
  output logic [0:0]  m_tuser,   // [0] divisor_zero
  // calibration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ptc_pkg::*;

  // Calibration registers
  logic [47:0] temp_calib;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_mid;
  logic [15:0] press_calib_last;
  calib_t      calib;

  // Pipeline advance: the whole datapath moves together while the skid is empty
  logic adv;

  logic               t_valid;
  logic signed [14:0] t_temp;
  logic signed [24:0] t_fine;
  logic [19:0]        t_rp;

  logic               pre_valid;
  logic signed [63:0] pre_num;
  logic signed [31:0] pre_den;
  logic               pre_zero;
  logic signed [14:0] pre_temp;

  logic               div_valid;
  logic signed [63:0] div_quot;
  logic               div_zero;
  logic signed [14:0] div_temp;

  logic    post_valid;
  result_t post_result;
  result_t out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_low  <= '0;
      press_calib_mid  <= '0;
      press_calib_last <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_CALIB: temp_calib       <= cfg_data[47:0];
        REG_PRESS_LOW:  press_calib_low  <= cfg_data;
        REG_PRESS_MID:  press_calib_mid  <= cfg_data;
        REG_PRESS_LAST: press_calib_last <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Unpack the 16-bit calibration words
  always_comb begin
    calib.t1 = temp_calib[15:0];
    calib.t2 = temp_calib[31:16];
    calib.t3 = temp_calib[47:32];
    calib.p1 = press_calib_low[15:0];
    calib.p2 = press_calib_low[31:16];
    calib.p3 = press_calib_low[47:32];
    calib.p4 = press_calib_low[63:48];
    calib.p5 = press_calib_mid[15:0];
    calib.p6 = press_calib_mid[31:16];
    calib.p7 = press_calib_mid[47:32];
    calib.p8 = press_calib_mid[63:48];
    calib.p9 = press_calib_last;
  end

  assign s_tready = adv;

  // Temperature and t_fine
  ptc_temp u_temp (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (s_tvalid),
    .raw_t      (s_tdata[19:0]),
    .raw_p      (s_tdata[39:20]),
    .calib      (calib),
    .out_valid  (t_valid),
    .temp_centi (t_temp),
    .t_fine     (t_fine),
    .raw_p_out  (t_rp)
  );

  // Dividend and divisor for the pressure quotient
  ptc_press_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (t_valid),
    .t_fine    (t_fine),
    .raw_p     (t_rp),
    .temp_in   (t_temp),
    .calib     (calib),
    .out_valid (pre_valid),
    .num       (pre_num),
    .den       (pre_den),
    .zero      (pre_zero),
    .temp_out  (pre_temp)
  );

  // Truncating signed divide; result is ignored when the divisor is zero
  ptc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pre_valid),
    .num       (pre_num),
    .den       (pre_den),
    .zero_in   (pre_zero),
    .temp_in   (pre_temp),
    .out_valid (div_valid),
    .quot      (div_quot),
    .zero_out  (div_zero),
    .temp_out  (div_temp)
  );

  // Second-order correction, scaling to 0.01 Pa and clamp
  ptc_press_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (div_valid),
    .p_in      (div_quot),
    .zero_in   (div_zero),
    .temp_in   (div_temp),
    .calib     (calib),
    .out_valid (post_valid),
    .result    (post_result)
  );

  // Output register plus skid word; hold the pipeline while the skid is full
  ptc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (post_valid),
    .in_data   (post_result),
    .in_ready  (adv),
    .out_valid (m_tvalid),
    .out_data  (out_result),
    .out_ready (m_tready)
  );

  assign m_tdata = {1'b0, out_result.pressure_centi_pa, out_result.temperature_centi};
  assign m_tuser = out_result.divisor_zero;

endmodule

// File: bench/ptc_checker.sv
// Checker for the pressure/temperature compensation core: predicts each result word
// from the accepted input words and the calibration writes, and compares them.
// Depends on ptc_pkg.
module ptc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  logic [47:0] temp_calib;
  logic [63:0] press_low, press_mid;
  logic [15:0] press_last;
  result_t     expected_q[$];

  assign pending = expected_q.size();

  function automatic longint sdiv(longint a, longint b);
    if (b == 0) return 0;
    if (a == 64'sh8000000000000000 && b == -1) return a;
    return a / b;
  endfunction

  function automatic longint sw(logic [63:0] r, int slot);
    logic signed [15:0] w;
    w = r[16*slot +: 16];
    return longint'(w);
  endfunction

  function automatic result_t compensate(logic [19:0] rt_raw, logic [19:0] rp_raw);
    longint rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint v1, v2, d, tf, temp, a, b, p, pres;
    result_t r;
    rt = longint'(rt_raw);
    rp = longint'(rp_raw);
    t1 = longint'(temp_calib[15:0]);
    t2 = sw(temp_calib, 1);
    t3 = sw(temp_calib, 2);
    p1 = longint'(press_low[15:0]);
    p2 = sw(press_low, 1);
    p3 = sw(press_low, 2);
    p4 = sw(press_low, 3);
    p5 = sw(press_mid, 0);
    p6 = sw(press_mid, 1);
    p7 = sw(press_mid, 2);
    p8 = sw(press_mid, 3);
    p9 = sw(press_last, 0);
    r = '0;
    v1 = ((rt / 8) - 2 * t1) * t2 / 2048;
    d = rt / 16 - t1;
    v2 = ((d * d) / 4096) * t3 / 16384;
    tf = v1 + v2;
    temp = (tf * 5 + 128) / 256;
    if (temp < TEMP_MIN_CENTI) temp = TEMP_MIN_CENTI;
    else if (temp > TEMP_MAX_CENTI) temp = TEMP_MAX_CENTI;
    r.temperature_centi = temp[14:0];
    // 64-bit wrapping arithmetic, as longint does natively
    a = tf - 128000;
    b = a * a * p6;
    b = b + a * p5 * 131072;
    b = b + p4 * 64'sd34359738368;
    a = sdiv(a * a * p3, 256) + a * p2 * 4096;
    a = sdiv((64'sd140737488355328 + a) * p1, 64'sd8589934592);
    if (a == 0) begin
      r.divisor_zero = 1'b1;
    end else begin
      p = 1048576 - rp;
      p = sdiv((p * 64'sd2147483648 - b) * 3125, a);
      a = sdiv(p9 * sdiv(p, 8192) * sdiv(p, 8192), 33554432);
      b = sdiv(p8 * p, 524288);
      p = sdiv(p + a + b, 256) + p7 * 16;
      pres = sdiv(sdiv(p, 2) * 100, 128);
      if (pres < PRESS_MIN_CENTI) pres = PRESS_MIN_CENTI;
      else if (pres > PRESS_MAX_CENTI) pres = PRESS_MAX_CENTI;
      r.pressure_centi_pa = pres[23:0];
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      temp_calib <= '0;
      press_low  <= '0;
      press_mid  <= '0;
      press_last <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TEMP_CALIB: temp_calib <= cfg_data[47:0];
          REG_PRESS_LOW:  press_low  <= cfg_data;
          REG_PRESS_MID:  press_mid  <= cfg_data;
          REG_PRESS_LAST: press_last <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_q.push_back(compensate(s_tdata[19:0], s_tdata[39:20]));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected word", m_tdata, 0);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[14:0] !== want.temperature_centi)
            report("temperature", m_tdata[14:0], want.temperature_centi);
          if (m_tdata[38:15] !== want.pressure_centi_pa)
            report("pressure", m_tdata[38:15], want.pressure_centi_pa);
          if (m_tdata[39] !== 1'b0)
            report("pad bit", m_tdata[39], 0);
          if (m_tuser[0] !== want.divisor_zero)
            report("divisor_zero", m_tuser[0], want.divisor_zero);
        end
      end
    end
  end
endmodule

// File: bench/testbench.sv
// Top of the compensation core bench: clock, reset, calibration phases, sample stimulus
// and the verdict. Depends on ptc_pkg, the core and ptc_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_TEMP_CALIB;
  logic [63:0] cfg_data = '0;
  int          errors;
  int          pending;
  logic        sink_on = 1'b0;

  always #5 clk = ~clk;

  pressure_temperature_compensation_core u_dut (.*);

  ptc_checker u_checker (.*);

  // Hold the limit far beyond the slowest run: 1516 words, each with the longest input gap
  // plus the longest sink stall, plus drains.
  initial begin
    #20ms;
    $display("FAIL pressure_temperature_compensation_core");
    $finish;
  end

  // Sink side: drop ready for a random wait before each accept; some stretches run free.
  initial begin
    int wait_n;
    bit free_run;
    free_run = 0;
    forever begin
      @(posedge clk);
      if (!sink_on) begin
        m_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) free_run = !free_run;
        wait_n = free_run ? 0 : $urandom_range(0, 15);
        if (wait_n > 0) begin
          m_tready <= 1'b0;
          repeat (wait_n - 1) @(posedge clk);
          @(posedge clk);
        end
        m_tready <= 1'b1;
        do @(posedge clk); while (!m_tvalid);
        m_tready <= $urandom_range(0, 1);
      end
    end
  end

  // Write one calibration register; the pipeline must be empty.
  task automatic write_calib(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drive one sample word and hold it until accepted; with no gap the next word
  // follows in the very next cycle, otherwise drop valid for the gap.
  task automatic send_sample(logic [19:0] rt, logic [19:0] rp, bit gapless);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rp, rt};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid, wait until every expected result has come out, then let the pipeline settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Typical factory words, so pressure lands in range most of the time.
  task automatic typical_calib();
    logic [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    t1 = 16'd27504 + 16'($urandom_range(0, 4000)) - 16'd2000;
    t2 = 16'sd26435 + 16'($urandom_range(0, 2000)) - 16'sd1000;
    t3 = -16'sd1000 + 16'($urandom_range(0, 2000));
    p1 = 16'd36477 + 16'($urandom_range(0, 4000)) - 16'd2000;
    p2 = -16'sd10685 + 16'($urandom_range(0, 400)) - 16'sd200;
    p3 = 16'sd3024 + 16'($urandom_range(0, 200)) - 16'sd100;
    p4 = 16'sd2855 + 16'($urandom_range(0, 200)) - 16'sd100;
    p5 = 16'sd140 + 16'($urandom_range(0, 40)) - 16'sd20;
    p6 = -16'sd7;
    p7 = 16'sd15500 + 16'($urandom_range(0, 400)) - 16'sd200;
    p8 = -16'sd14600 + 16'($urandom_range(0, 400)) - 16'sd200;
    p9 = 16'sd6000 + 16'($urandom_range(0, 400)) - 16'sd200;
    write_calib(REG_TEMP_CALIB, {16'h0, t3, t2, t1});
    write_calib(REG_PRESS_LOW, {p4, p3, p2, p1});
    write_calib(REG_PRESS_MID, {p8, p7, p6, p5});
    write_calib(REG_PRESS_LAST, {48'h0, p9});
  endtask

  initial begin
    logic [19:0] rt, rp;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    sink_on <= 1'b1;

    // Reset calibration: p1 = 0 gives the zero divisor on every word.
    send_sample(20'h0, 20'h0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 0);
    drain();

    // Typical words: range ends of both raw fields, clamps at both temperature limits.
    typical_calib();
    send_sample(20'h0, 20'h0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 1);
    send_sample(20'd519888, 20'd415148, 1);
    send_sample(20'h0, 20'hFFFFF, 0);
    send_sample(20'hFFFFF, 20'h0, 0);
    send_sample(20'h80000, 20'h80000, 0);
    send_sample(20'h55555, 20'hAAAAA, 0);
    send_sample(20'hAAAAA, 20'h55555, 0);
    drain();

    // Extreme words: all ones, most negative and most positive, to reach wrapping paths.
    write_calib(REG_TEMP_CALIB, 64'hFFFF_FFFF_FFFF_FFFF);
    write_calib(REG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_calib(REG_PRESS_MID, 64'hFFFF_FFFF_FFFF_FFFF);
    write_calib(REG_PRESS_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(20'h0, 20'h0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 0);
    send_sample(20'h12345, 20'h6789A, 0);
    drain();
    write_calib(REG_TEMP_CALIB, 64'h0000_8000_7FFF_0000);
    write_calib(REG_PRESS_LOW, 64'h7FFF_8000_7FFF_FFFF);
    write_calib(REG_PRESS_MID, 64'h8000_7FFF_8000_7FFF);
    write_calib(REG_PRESS_LAST, 64'h0000_0000_0000_8000);
    send_sample(20'h0, 20'h0, 0);
    send_sample(20'hFFFFF, 20'hFFFFF, 0);
    send_sample(20'h80000, 20'h00001, 0);
    drain();

    // Random phases: mostly realistic calibration, some fully random words.
    for (int phase = 0; phase < 12; phase++) begin
      if (phase % 4 == 3) begin
        write_calib(REG_TEMP_CALIB, {$urandom, $urandom});
        write_calib(REG_PRESS_LOW, {$urandom, $urandom});
        write_calib(REG_PRESS_MID, {$urandom, $urandom});
        write_calib(REG_PRESS_LAST, {$urandom, $urandom});
      end else begin
        typical_calib();
      end
      for (int k = 0; k < 125; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          rt = 20'($urandom);
          rp = 20'($urandom);
        end else begin
          rt = 20'($urandom_range(380000, 660000));
          rp = 20'($urandom_range(150000, 650000));
        end
        send_sample(rt, rp, $urandom_range(0, 3) == 0);
      end
      drain();
    end

    if (errors == 0)
      $display("PASS pressure_temperature_compensation_core");
    else
      $display("FAIL pressure_temperature_compensation_core");
    $finish;
  end
endmodule
